@@ design/char_ring_frame_packetizer_defines.svh @@
// ----------------------------------------------------------------------------
// Console packetizer assertion macros
// Shared property wrappers for the console character packetizer checks.
// ----------------------------------------------------------------------------
`ifndef CHAR_RING_FRAME_PACKETIZER_DEFINES_SVH
`define CHAR_RING_FRAME_PACKETIZER_DEFINES_SVH

// Checks that a condition implies another one in the same cycle.
`define CRFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define CRFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/crfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Console packetizer package
// Types, constants and ring helpers for the console character packetizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crfp_pkg;

  // Ring and frame geometry.
  localparam int BUFFER_DEPTH = 128;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int FRAME_BYTES  = 8;
  localparam int IDX_W        = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int LEN_W        = 4;
  localparam int PAYLOAD_W    = 64;
  localparam int RESULT_CAP   = 16;
  localparam int CNT_W        = $clog2(RESULT_CAP + 1);

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] LIMIT_RESET  = 8'd100;
  localparam logic [7:0] NL_MAX       = 8'hff;

  // Command codes carried by an input request.
  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_ENABLE = 2'd2
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_READ,
    ST_TAKE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_byte;
    logic [7:0] requester_address;
    logic       link_ready;
    logic       bus_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           frame_dest;
    logic [LEN_W-1:0]     payload_length;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last_frame;
  } out_item_t;

  // Advances a ring pointer with wrap at the buffer depth.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
    if (ptr == PTR_W'(BUFFER_DEPTH - 1)) begin
      return '0;
    end
    return ptr + PTR_W'(1);
  endfunction

  // Number of bytes held between the read and write pointers.
  function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] wr,
                                                 input logic [PTR_W-1:0] rd);
    logic [PTR_W:0] sum;
    sum = {1'b0, wr} + (PTR_W + 1)'(BUFFER_DEPTH) - {1'b0, rd};
    if (wr >= rd) begin
      return wr - rd;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ design/char_ring_frame_packetizer.sv @@
// ----------------------------------------------------------------------------
// Console character packetizer
// Buffers console characters in a ring and cuts them into frames of up to
// eight bytes for the active session destination.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                      Direction  Content
//  in        in_valid/in_ready/in_data    sink       command and character
//  out       out_valid/out_ready/out_data source     up to 16 frames per request
//  cfg       cfg_valid/cfg_ready/cfg_data sink       session frame limit
//
// One request at a time: accept, a decode (exec) state, then a check state before
// the first frame. Each frame reads each byte through the ring memory's
// registered read port in a read state and a take state, then passes a check
// state and a send state. A dropped request, an enable, or a poll with no retry
// pending returns to idle from the exec state.
// Reset (rst, synchronous) empties the ring, closes the session and loads a
// frame limit of 100. The ring memory is not cleared.
// A stalled out_ready holds the sequencer in the send state with the frame.
`timescale 1ns / 1ps
`include "char_ring_frame_packetizer_defines.svh"

module char_ring_frame_packetizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  crfp_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output crfp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import crfp_pkg::*;

  state_t               state;
  state_t               state_next;
  in_item_t             req_q;
  out_item_t            out_q;
  logic [7:0]           mem [BUFFER_DEPTH];
  logic [7:0]           mem_q;
  logic [PTR_W-1:0]     write_index;
  logic [PTR_W-1:0]     read_index;
  logic [7:0]           newline_count;
  logic                 retry_pending;
  logic [7:0]           session_dest;
  logic [7:0]           frames_remaining;
  logic [7:0]           frame_limit;
  logic [CNT_W-1:0]     sent_count;
  logic [IDX_W-1:0]     byte_idx;
  logic [LEN_W-1:0]     frame_len;
  logic [PAYLOAD_W-1:0] asm_payload;
  logic                 frame_pending;
  logic                 more_frames;

  logic [PTR_W-1:0]     fill;
  logic                 put_ok;
  logic                 put_we;
  logic [7:0]           nl_after_put;
  logic                 put_flush;
  logic                 fl_empty;
  logic                 fl_short;
  logic                 fl_emit;
  logic [LEN_W-1:0]     next_len;
  logic                 take_last;
  logic [PAYLOAD_W-1:0] asm_next;
  logic [7:0]           frames_dec;

  // Ring occupancy and the put-character decision.
  always_comb begin
    fill         = ring_fill(write_index, read_index);
    put_ok       = (session_dest != 8'd0) && req_q.bus_ok &&
                   (fill != PTR_W'(BUFFER_DEPTH - 1));
    put_we       = (state == ST_EXEC) && (req_q.command == CMD_PUT) && put_ok;
    nl_after_put = newline_count;
    if (req_q.char_byte == NEWLINE_CHAR && newline_count != NL_MAX) begin
      nl_after_put = newline_count + 8'd1;
    end
    put_flush = (fill >= PTR_W'(FRAME_BYTES - 1)) || (nl_after_put != 8'd0);
  end

  // Flush decision for the next frame.
  always_comb begin
    fl_empty = (fill == '0);
    fl_short = (fill < PTR_W'(FRAME_BYTES)) && (newline_count == 8'd0);
    fl_emit  = !fl_empty && !fl_short && req_q.link_ready &&
               (sent_count < CNT_W'(RESULT_CAP));
    next_len = (fill >= PTR_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES) : LEN_W'(fill);
  end

  // Byte assembly for the frame being read out of the ring.
  always_comb begin
    asm_next = asm_payload;
    asm_next[{byte_idx, 3'b000} +: 8] = mem_q;
    take_last  = (LEN_W'(byte_idx) == frame_len - LEN_W'(1));
    frames_dec = frames_remaining - 8'd1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_q.command)
          CMD_PUT:  state_next = (put_ok && put_flush) ? ST_CHECK : ST_IDLE;
          CMD_POLL: state_next = retry_pending ? ST_CHECK : ST_IDLE;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_CHECK: begin
        if (frame_pending) begin
          state_next = ST_SEND;
        end else if (fl_emit) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: state_next = ST_TAKE;
      ST_TAKE: state_next = take_last ? ST_CHECK : ST_READ;
      ST_SEND: begin
        if (out_ready) begin
          state_next = more_frames ? ST_READ : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_SEND);
    cfg_ready = 1'b1;
    out_data  = out_q;
  end

  // Ring memory with a registered read port at the read pointer.
  always_ff @(posedge clk) begin
    if (put_we) begin
      mem[write_index] <= req_q.char_byte;
    end
    mem_q <= mem[read_index];
  end

  // Sequencer and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      write_index      <= '0;
      read_index       <= '0;
      newline_count    <= 8'd0;
      retry_pending    <= 1'b0;
      session_dest     <= 8'd0;
      frames_remaining <= 8'd0;
      frame_limit      <= LIMIT_RESET;
      sent_count       <= '0;
      frame_pending    <= 1'b0;
      more_frames      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        frame_limit <= cfg_data;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_q         <= in_data;
            sent_count    <= '0;
            frame_pending <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (put_we) begin
            write_index   <= ring_next(write_index);
            newline_count <= nl_after_put;
          end
          if (req_q.command == CMD_ENABLE) begin
            session_dest     <= req_q.requester_address;
            frames_remaining <= frame_limit;
          end
        end
        ST_CHECK: begin
          // A held frame is the last one when no further frame follows.
          out_q.last_frame <= !fl_emit;
          frame_pending    <= 1'b0;
          more_frames      <= fl_emit;
          if (fl_emit) begin
            frame_len   <= next_len;
            byte_idx    <= '0;
            asm_payload <= '0;
          end else if (fl_empty) begin
            retry_pending <= 1'b0;
            newline_count <= 8'd0;
          end else if (fl_short) begin
            retry_pending <= 1'b0;
          end else begin
            retry_pending <= 1'b1;
          end
        end
        ST_TAKE: begin
          read_index  <= ring_next(read_index);
          asm_payload <= asm_next;
          byte_idx    <= byte_idx + IDX_W'(1);
          if (mem_q == NEWLINE_CHAR && newline_count != 8'd0) begin
            newline_count <= newline_count - 8'd1;
          end
          // Last byte: the frame is complete and spends one unit of budget.
          if (take_last) begin
            out_q.frame_dest     <= session_dest;
            out_q.payload_length <= frame_len;
            out_q.payload        <= asm_next;
            frames_remaining     <= frames_dec;
            if (frames_dec == 8'd0) begin
              session_dest <= 8'd0;
            end
            sent_count    <= sent_count + CNT_W'(1);
            frame_pending <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Checks on the sequencer.
  `CRFP_ASSERT_SAME(a_no_overlap, out_valid, !in_ready, "frame shown while taking requests")
  `CRFP_ASSERT_SAME(a_frame_cap, out_valid,
    (sent_count != '0) && (sent_count <= CNT_W'(RESULT_CAP)),
    "frame count per request out of range")
  `CRFP_ASSERT_SAME(a_len_range, out_valid,
    (out_data.payload_length != '0) &&
    (out_data.payload_length <= LEN_W'(FRAME_BYTES)),
    "frame length out of range")
  `CRFP_ASSERT_NEXT(a_last_ends, out_valid && out_ready && out_data.last_frame, in_ready,
    "request not finished after its last frame")

endmodule
